// ===== sv/hdt_pkg.sv =====
// Package for the handheld divider and timer block.
// Types, fixed periods and the timer rate table; no dependencies.
package hdt_pkg;

    localparam int AccW   = 16;
    localparam int CountW = 8;
    localparam int CycW   = 5;

    localparam logic [AccW-1:0] DivPeriod     = 16'd256;
    localparam logic [AccW-1:0] DivPeriodFast = 16'd512;

    // timer_control fields
    localparam int CtrlW      = 3;
    localparam int CtrlEnBit  = 2;

    // register indexes on the configuration port
    localparam int CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] RegTimerControl = 2'd0;
    localparam logic [CfgIdxW-1:0] RegReloadValue  = 2'd1;
    localparam logic [CfgIdxW-1:0] RegDoubleSpeed  = 2'd2;

    typedef enum logic [1:0] {
        RATE_1024 = 2'd0,
        RATE_16   = 2'd1,
        RATE_64   = 2'd2,
        RATE_256  = 2'd3
    } rate_sel_t;

    typedef struct packed {
        logic [AccW-1:0]   div_accum;
        logic [CountW-1:0] div_count;
        logic [AccW-1:0]   tmr_prescale;
        logic [CountW-1:0] tmr_count;
        logic              ovf_pending;
    } state_t;

    typedef struct packed {
        logic              tmr_enable;
        rate_sel_t         rate_sel;
        logic [CountW-1:0] reload_value;
        logic              double_speed;
    } cfg_t;

    typedef struct packed {
        logic [CountW-1:0] divider_value;
        logic [CountW-1:0] timer_value;
        logic              timer_irq;
    } result_t;

    // base timer period for a rate select, before double-speed scaling
    function automatic logic [AccW-1:0] timer_period(input rate_sel_t sel);
        logic [AccW-1:0] p;
        unique case (sel)
            RATE_1024: p = 16'd1024;
            RATE_16:   p = 16'd16;
            RATE_64:   p = 16'd64;
            RATE_256:  p = 16'd256;
            default:   p = 16'd1024;
        endcase
        return p;
    endfunction

endpackage

// ===== sv/hdt_step.sv =====
// Next-state logic for one transfer: overflow service, divider, timer.
// Depends on hdt_pkg.
module hdt_step (
    input  hdt_pkg::state_t       state_cur,
    input  hdt_pkg::cfg_t         cfg,
    input  logic [4:0]            cycles,
    output hdt_pkg::state_t       state_new,
    output hdt_pkg::result_t      result
);
    import hdt_pkg::*;

    logic [AccW-1:0] div_per;
    logic [AccW-1:0] tmr_base;
    logic [AccW-1:0] tmr_per;
    logic [AccW-1:0] cyc_ext;

    assign cyc_ext  = {{(AccW-CycW){1'b0}}, cycles};
    assign div_per  = cfg.double_speed ? DivPeriodFast : DivPeriod;
    assign tmr_base = timer_period(cfg.rate_sel);
    assign tmr_per  = cfg.double_speed ? {tmr_base[AccW-2:0], 1'b0} : tmr_base;

    always_comb begin
        state_new        = state_cur;
        result.timer_irq = 1'b0;

        // pending overflow is serviced before any counting
        if (state_cur.ovf_pending) begin
            state_new.tmr_count   = cfg.reload_value;
            state_new.ovf_pending = 1'b0;
            result.timer_irq      = 1'b1;
        end

        // at most one divider tick per transfer
        state_new.div_accum = state_cur.div_accum + cyc_ext;
        if (state_new.div_accum >= div_per) begin
            state_new.div_accum = state_new.div_accum - div_per;
            state_new.div_count = state_cur.div_count + 8'd1;
        end

        if (cfg.tmr_enable) begin
            state_new.tmr_prescale = state_cur.tmr_prescale + cyc_ext;
            if (state_new.tmr_prescale >= tmr_per) begin
                state_new.tmr_prescale = state_new.tmr_prescale - tmr_per;
                state_new.tmr_count    = state_new.tmr_count + 8'd1;
                if (state_new.tmr_count == '0) begin
                    state_new.ovf_pending = 1'b1;
                end
            end
        end

        result.divider_value = state_new.div_count;
        result.timer_value   = state_new.tmr_count;
    end

endmodule

// ===== sv/handheld_divider_and_timer.sv =====
// Divider and timer block: top level with input stage, state and result stage.
// Input and result stages are both registered; one transfer per cycle sustained while m_tready is high.
// State, configuration and valid flags clear on synchronous active-low aresetn.
// Depends on hdt_pkg and hdt_step.
module handheld_divider_and_timer (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wr_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [4:0] elapsed_cycles, [7:5] zero
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [7:0] divider_value, [15:8] timer_value,
                                   // [16] timer_irq, [23:17] zero
);
    import hdt_pkg::*;

    // configuration registers
    logic [CtrlW-1:0]  timer_control_reg;
    logic [CountW-1:0] reload_value_reg;
    logic              double_speed_reg;

    // input stage
    logic              in_valid_reg;
    logic [CycW-1:0]   in_cycles_reg;

    // counter state, updated as an item moves into the result stage
    state_t            state_reg;
    state_t            state_next;

    // result stage
    logic              out_valid_reg;
    result_t           out_reg;
    result_t           out_next;

    cfg_t              cfg;
    logic              advance;

    assign cfg.tmr_enable   = timer_control_reg[CtrlEnBit];
    assign cfg.rate_sel     = rate_sel_t'(timer_control_reg[1:0]);
    assign cfg.reload_value = reload_value_reg;
    assign cfg.double_speed = double_speed_reg;

    // the input stage moves on whenever the result stage is empty or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    hdt_step u_step (
        .state_cur (state_reg),
        .cfg       (cfg),
        .cycles    (in_cycles_reg),
        .state_new (state_next),
        .result    (out_next)
    );

    // configuration writes; upper data bits beyond a register's width are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_control_reg <= '0;
            reload_value_reg  <= '0;
            double_speed_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                RegTimerControl: timer_control_reg <= cfg_wr_data[CtrlW-1:0];
                RegReloadValue:  reload_value_reg  <= cfg_wr_data;
                RegDoubleSpeed:  double_speed_reg  <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // input stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cycles_reg <= s_tdata[CycW-1:0];
        end
    end

    // counter state advances exactly once per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.timer_irq, out_reg.timer_value, out_reg.divider_value};

endmodule

// ===== sim/hdt_checker.sv =====
`timescale 1ns / 1ps
// Checker for the handheld divider and timer: watches the config port and both streams,
// predicts every readout and compares it with what the block sends.
// Depends on hdt_pkg.
module hdt_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [4:0] elapsed_cycles
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,    // [7:0] divider_value, [15:8] timer_value, [16] timer_irq
    output int          fail_count,
    output int          outstanding
);
    import hdt_pkg::*;

    // predicted state
    logic [AccW-1:0]   div_acc;
    logic [CountW-1:0] div_cnt;
    logic [AccW-1:0]   tmr_acc;
    logic [CountW-1:0] tmr_cnt;
    logic              ovf_pend;

    // shadow of the registers
    logic              tmr_en;
    rate_sel_t         rate;
    logic [CountW-1:0] reload;
    logic              dbl;

    result_t readouts[$];

    function automatic logic [AccW-1:0] tick_period(input rate_sel_t r);
        case (r)
            RATE_16:  return 16'd16;
            RATE_64:  return 16'd64;
            RATE_256: return 16'd256;
            default:  return 16'd1024;
        endcase
    endfunction

    // one instruction step: pending reload first, then divider, then timer
    task automatic step_timers(input logic [CycW-1:0] cyc, output result_t r);
        logic            irq;
        logic [AccW-1:0] per;
        irq = 1'b0;
        if (ovf_pend) begin
            tmr_cnt  = reload;
            irq      = 1'b1;
            ovf_pend = 1'b0;
        end
        div_acc = div_acc + AccW'(cyc);
        per = dbl ? DivPeriodFast : DivPeriod;
        if (div_acc >= per) begin
            div_acc = div_acc - per;
            div_cnt = div_cnt + 1'b1;
        end
        if (tmr_en) begin
            tmr_acc = tmr_acc + AccW'(cyc);
            per = tick_period(rate);
            if (dbl)
                per = per << 1;
            if (tmr_acc >= per) begin
                tmr_acc = tmr_acc - per;
                tmr_cnt = tmr_cnt + 1'b1;
                if (tmr_cnt == '0)
                    ovf_pend = 1'b1;
            end
        end
        r.divider_value = div_cnt;
        r.timer_value   = tmr_cnt;
        r.timer_irq     = irq;
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            div_acc  = '0;
            div_cnt  = '0;
            tmr_acc  = '0;
            tmr_cnt  = '0;
            ovf_pend = 1'b0;
            tmr_en   = 1'b0;
            rate     = RATE_1024;
            reload   = '0;
            dbl      = 1'b0;
            readouts.delete();
        end else begin
            // readout out first: it always belongs to an earlier transfer
            if (m_tvalid && m_tready) begin
                got.divider_value = m_tdata[7:0];
                got.timer_value   = m_tdata[15:8];
                got.timer_irq     = m_tdata[16];
                if (readouts.size() == 0) begin
                    $error("readout with nothing predicted: tdata %h", m_tdata);
                    fail_count++;
                end else begin
                    want = readouts.pop_front();
                    if (got.divider_value !== want.divider_value) begin
                        $error("divider_value expected %0d got %0d",
                               want.divider_value, got.divider_value);
                        fail_count++;
                    end
                    if (got.timer_value !== want.timer_value) begin
                        $error("timer_value expected %0d got %0d",
                               want.timer_value, got.timer_value);
                        fail_count++;
                    end
                    if (got.timer_irq !== want.timer_irq) begin
                        $error("timer_irq expected %0d got %0d",
                               want.timer_irq, got.timer_irq);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                step_timers(s_tdata[CycW-1:0], want);
                readouts.push_back(want);
            end
            // register writes count from the next step on
            if (cfg_wr_en) begin
                case (cfg_index)
                    RegTimerControl: begin
                        tmr_en = cfg_wr_data[CtrlEnBit];
                        rate   = rate_sel_t'(cfg_wr_data[1:0]);
                    end
                    RegReloadValue:  reload = cfg_wr_data[CountW-1:0];
                    RegDoubleSpeed:  dbl    = cfg_wr_data[0];
                    default: ;
                endcase
            end
        end
        outstanding = readouts.size();
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Top of the divider and timer testbench: clock, reset, stimulus, idling and verdict.
// Depends on hdt_pkg, hdt_checker and the handheld_divider_and_timer RTL.
module testbench;
    import hdt_pkg::*;

    localparam int StallLimit  = 1000;  // cycles with no transfer before giving up
    localparam int DrainCycles = 8;     // settle time after the last readout
    localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;            // [4:0] elapsed_cycles, [7:5] zero
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [23:0] m_tdata;            // [7:0] divider_value, [15:8] timer_value, [16] timer_irq

    int fail_count;
    int outstanding;
    int idle_mode = 0;               // 0 none, 1 sender gaps, 2 receiver stalls, 3 both light
    int quiet_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    handheld_divider_and_timer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    hdt_checker timer_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // chance in a hundred that a side idles this cycle, by phase
    function automatic int sender_gap_pct();
        return (idle_mode == 1) ? 77 : (idle_mode == 3) ? 13 : 0;
    endfunction

    function automatic int receiver_stall_pct();
        return (idle_mode == 2) ? 77 : (idle_mode == 3) ? 13 : 0;
    endfunction

    // receiver back-pressure, changed on the falling edge only
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct());
    end

    // watchdog: a long stretch with no transfer on either side means a hang
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("** handheld_divider_and_timer: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // mostly in the documented range, with the odd out-of-range and zero step
    function automatic logic [CycW-1:0] pick_cycles();
        int r;
        r = $urandom_range(99);
        if (r < 6)
            return '0;
        if (r < 16)
            return CycW'($urandom_range(31, 25));
        return CycW'($urandom_range(24));
    endfunction

    // one input transfer; tvalid stays up into the next call when no gap is drawn
    task automatic send_cycles(input logic [CycW-1:0] cyc);
        @(negedge aclk);
        while ($urandom_range(99) < sender_gap_pct()) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = 8'(cyc);
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // drop tvalid and hold off until every predicted readout has been checked
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
        repeat (DrainCycles) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] data);
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_index   = idx;
        cfg_wr_data = data;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    // all three registers; unused upper bits carry junk, which must be ignored
    task automatic set_timers(input logic en, input rate_sel_t sel,
                              input logic [7:0] reload, input logic dbl);
        logic [7:0] ctrl;
        logic [7:0] ds;
        ctrl = 8'($urandom);
        ctrl[CtrlEnBit]  = en;
        ctrl[1:0]        = sel;
        ds    = 8'($urandom);
        ds[0] = dbl;
        write_reg(RegTimerControl, ctrl);
        write_reg(RegReloadValue, reload);
        write_reg(RegDoubleSpeed, ds);
    endtask

    // per-phase settings: extremes first, then random
    logic      ph_en[8]     = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    rate_sel_t ph_rate[8]   = '{RATE_1024, RATE_16, RATE_256, RATE_64,
                                RATE_256, RATE_16, RATE_64, RATE_1024};
    logic [7:0] ph_reload[8] = '{8'h00, 8'hFF, 8'hF0, 8'hFC, 8'h5A, 8'hFE, 8'h00, 8'h00};
    logic      ph_dbl[8]    = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

    logic [CycW-1:0] bit_walk[8] = '{5'd0, 5'd31, 5'd24, 5'd16, 5'd8, 5'd4, 5'd2, 5'd1};

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset settings: timer off, divider only; walk every cycle bit
        foreach (bit_walk[i])
            send_cycles(bit_walk[i]);
        drain();

        // fastest rate, double speed: at most one tick per step with carried remainder
        set_timers(1'b1, RATE_16, 8'hFF, 1'b1);
        repeat (6) send_cycles(5'd31);
        send_cycles(5'd0);
        send_cycles(5'd24);
        drain();

        // timer off again; a write to the spare index must change nothing
        set_timers(1'b0, RATE_1024, 8'h00, 1'b0);
        write_reg(RegUnused, 8'hFF);
        send_cycles(5'd31);
        send_cycles(5'd24);
        drain();

        // run at rate 16: a tick every step, the counter overflows and then,
        // reloaded with FF, overflows again straight away; prescaler climbs by 15
        set_timers(1'b1, RATE_16, 8'hFF, 1'b0);
        repeat (300) send_cycles(5'd31);
        drain();

        // table phases then random ones, idling pattern rotating through all four modes
        for (int p = 0; p < 8; p++) begin
            idle_mode = p % 4;
            drain();
            if (p >= 6) begin
                set_timers(1'($urandom), rate_sel_t'($urandom_range(3)),
                           8'($urandom), 1'($urandom));
            end else begin
                set_timers(ph_en[p], ph_rate[p], ph_reload[p], ph_dbl[p]);
            end
            for (int n = 0; n < 70; n++) begin
                // sender hold-off mid-stream until the block has emptied
                if (p == 2 && n == 35)
                    drain();
                send_cycles(pick_cycles());
            end
        end

        idle_mode = 0;
        drain();
        if (fail_count == 0 && outstanding == 0) begin
            $display("** handheld_divider_and_timer: PASSED **");
        end else begin
            $display("** handheld_divider_and_timer: FAILED **");
        end
        $finish;
    end

endmodule
